// ===== hdl/fcct_pkg.sv =====
// ----------------------------------------------------------------------------
// fcct_pkg: shared types and constants of the fault code confirm table
// Command and result codes, the stored entry layout and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fcct_pkg;

  // command codes
  localparam logic [1:0] CMD_RAISE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;

  // entry flag bits and confirmation threshold
  localparam logic [1:0] FLAG_FAILED    = 2'b01;
  localparam logic [1:0] FLAG_CONFIRMED = 2'b10;
  localparam logic [1:0] CONFIRM_AT     = 2'd3;

  // most records a single read returns
  localparam logic [4:0] MAX_READ = 5'd16;

  typedef struct packed {
    logic [31:0] code;
    logic [1:0]  flags;
    logic [1:0]  count;
    logic [2:0]  severity;
  } fcct_entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture the input item
    logic       rd;        // read the entry at addr
    logic       wr_hit;    // update the matched entry at addr
    logic       wr_new;    // fill the free entry at addr
    logic       clr;       // free the entry at addr
    logic       hold;      // capture the current entry as pending record
    logic       emit;      // load the result register
    logic       emit_rec;  // result carries the pending record
    logic       last;
    logic [1:0] status;
    logic       conf;
  } fcct_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       occupied;
    logic       match;
    logic       confirmed;
    logic       mask_hit;
    logic       code_zero;
    logic       out_free;
    logic [4:0] lim;
  } fcct_sts_t;

endpackage

// ===== hdl/fault_code_confirm_table.sv =====
// ----------------------------------------------------------------------------
// fault_code_confirm_table: table of fault codes with confirmation counting
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
// The table holds ENTRIES fault codes, each with failed/confirmed flags, a
// saturating raise count and a severity. One command is taken at a time on
// the input channel. Raise, clear and query give one result with last set;
// a read gives one result per stored entry, in index order, up to
// min(read_limit, 16), or a single empty result when there is nothing to
// return. Every command but a raise of code zero walks the entry RAM, with
// a read step and an evaluate step per entry (set by the registered RAM read
// port); a raise that finds its code and a query that finds a confirmed code
// stop early, a read stops at its limit, and a read also waits whenever its
// result register is full.
// The input channel is ready again as soon as the last result is loaded
// into the result register, even while that result still waits for its
// transfer. Reset frees every entry at once through per-entry occupied bits.
module fault_code_confirm_table import fcct_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] fault_code,
  input  logic [2:0]  severity,
  input  logic [31:0] clear_mask,
  input  logic [7:0]  read_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_status,
  output logic        is_confirmed,
  output logic        record_valid,
  output logic [31:0] record_code,
  output logic [1:0]  record_flags,
  output logic [1:0]  record_count,
  output logic [2:0]  record_severity,
  output logic        last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  fcct_ctl_t     ctl;
  fcct_sts_t     sts;
  logic [IW-1:0] addr;

  // sequence the scan and the result transfers
  fcct_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl),
    .addr     (addr)
  );

  // hold the table, the pending record and the result register
  fcct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .fault_code      (fault_code),
    .severity        (severity),
    .clear_mask      (clear_mask),
    .read_limit      (read_limit),
    .addr            (addr),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_status   (result_status),
    .is_confirmed    (is_confirmed),
    .record_valid    (record_valid),
    .record_code     (record_code),
    .record_flags    (record_flags),
    .record_count    (record_count),
    .record_severity (record_severity),
    .last            (last)
  );

endmodule

// ===== hdl/fcct_ram.sv =====
// ----------------------------------------------------------------------------
// fcct_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fcct_dp.sv =====
// ----------------------------------------------------------------------------
// fcct_dp: datapath of the fault code confirm table
// Holds the command, the entry RAM with its occupied bits, the pending read
// record and the result register.
// ----------------------------------------------------------------------------
module fcct_dp import fcct_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    cmd,
  input  logic [31:0]   fault_code,
  input  logic [2:0]    severity,
  input  logic [31:0]   clear_mask,
  input  logic [7:0]    read_limit,
  input  logic [IW-1:0] addr,
  input  fcct_ctl_t     ctl,
  output fcct_sts_t     sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    result_status,
  output logic          is_confirmed,
  output logic          record_valid,
  output logic [31:0]   record_code,
  output logic [1:0]    record_flags,
  output logic [1:0]    record_count,
  output logic [2:0]    record_severity,
  output logic          last
);

  logic [1:0]   op;
  logic [31:0]  code;
  logic [2:0]   sev;
  logic [31:0]  mask;
  logic [7:0]   limit;
  logic [ENTRIES-1:0] vld;
  fcct_entry_t  rdata;
  fcct_entry_t  ent;
  fcct_entry_t  upd_ent;
  fcct_entry_t  new_ent;
  fcct_entry_t  pend;
  logic [1:0]   count_next;

  // capture the command
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op    <= cmd;
      code  <= fault_code;
      sev   <= severity;
      mask  <= clear_mask;
      limit <= read_limit;
    end
  end

  // occupied bits: an entry that is not occupied reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr_hit || ctl.wr_new) begin
      vld[addr] <= 1'b1;
    end else if (ctl.clr) begin
      vld[addr] <= 1'b0;
    end
  end

  fcct_ram #(
    .WIDTH ($bits(fcct_entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_hit || ctl.wr_new),
    .waddr (addr),
    .wdata (ctl.wr_new ? new_ent : upd_ent),
    .re    (ctl.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    ent = vld[addr] ? rdata : '0;

    count_next = (ent.count < CONFIRM_AT) ? ent.count + 2'd1 : ent.count;
    upd_ent.code     = ent.code;
    upd_ent.count    = count_next;
    upd_ent.flags    = ent.flags | FLAG_FAILED |
                       ((count_next == CONFIRM_AT) ? FLAG_CONFIRMED : 2'b00);
    upd_ent.severity = sev;

    new_ent.code     = code;
    new_ent.flags    = FLAG_FAILED;
    new_ent.count    = 2'd1;
    new_ent.severity = sev;
  end

  always_comb begin
    sts.op        = op;
    sts.occupied  = vld[addr];
    sts.match     = (ent.code == code);
    sts.confirmed = (ent.code == code) && ent.flags[1];
    sts.mask_hit  = |(ent.code & mask);
    sts.code_zero = (code == 32'd0);
    sts.out_free  = !out_valid || out_ready;
    sts.lim       = (limit > 8'(MAX_READ)) ? MAX_READ : limit[4:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.hold) begin
      pend <= ent;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      last <= ctl.last;
      if (ctl.emit_rec) begin
        result_status   <= ST_OK;
        is_confirmed    <= 1'b0;
        record_valid    <= 1'b1;
        record_code     <= pend.code;
        record_flags    <= pend.flags;
        record_count    <= pend.count;
        record_severity <= pend.severity;
      end else begin
        result_status   <= ctl.status;
        is_confirmed    <= ctl.conf;
        record_valid    <= 1'b0;
        record_code     <= '0;
        record_flags    <= '0;
        record_count    <= '0;
        record_severity <= '0;
      end
    end
  end

endmodule

// ===== hdl/fcct_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcct_ctrl: controller of the fault code confirm table
// Sequences the entry scan of every command and the result transfers.
// ----------------------------------------------------------------------------
module fcct_ctrl import fcct_pkg::*; #(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fcct_sts_t     sts,
  output fcct_ctl_t     ctl,
  output logic [IW-1:0] addr
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [1:0]    state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] free_idx, free_idx_next;
  logic          free_found, free_found_next;
  logic          hit, hit_next;
  logic          conf, conf_next;
  logic [4:0]    n, n_next;
  logic          have_pend, have_pend_next;
  logic          adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    idx        <= idx_next;
    free_idx   <= free_idx_next;
    free_found <= free_found_next;
    hit        <= hit_next;
    conf       <= conf_next;
    n          <= n_next;
    have_pend  <= have_pend_next;
  end

  assign addr = (state == S_FIN) ? free_idx : idx;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    free_idx_next   = free_idx;
    free_found_next = free_found;
    hit_next        = hit;
    conf_next       = conf;
    n_next          = n;
    have_pend_next  = have_pend;
    ctl             = '0;
    in_ready        = 1'b0;
    adv             = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load        = 1'b1;
          idx_next        = '0;
          n_next          = '0;
          free_found_next = 1'b0;
          hit_next        = 1'b0;
          conf_next       = 1'b0;
          have_pend_next  = 1'b0;
          state_next      = S_RD;
        end
      end

      S_RD: begin
        if ((sts.op == CMD_RAISE && sts.code_zero) ||
            (sts.op == CMD_READ && n == sts.lim)) begin
          state_next = S_FIN;
        end else begin
          ctl.rd     = 1'b1;
          state_next = S_EV;
        end
      end

      S_EV: begin
        unique case (sts.op)
          CMD_RAISE: begin
            if (sts.occupied && sts.match) begin
              ctl.wr_hit = 1'b1;
              hit_next   = 1'b1;
              state_next = S_FIN;
            end else begin
              if (!sts.occupied && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
              end
              adv = 1'b1;
            end
          end
          CMD_CLEAR: begin
            ctl.clr = sts.occupied && sts.mask_hit;
            adv     = 1'b1;
          end
          CMD_QUERY: begin
            if (sts.occupied && sts.confirmed) begin
              conf_next  = 1'b1;
              state_next = S_FIN;
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            // read: keep one record back so the final one can carry last
            if (sts.occupied) begin
              if (have_pend) begin
                if (sts.out_free) begin
                  ctl.emit     = 1'b1;
                  ctl.emit_rec = 1'b1;
                  ctl.hold     = 1'b1;
                  n_next       = n + 5'd1;
                  adv          = 1'b1;
                end
              end else begin
                ctl.hold       = 1'b1;
                have_pend_next = 1'b1;
                n_next         = n + 5'd1;
                adv            = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
        endcase
        if (adv) begin
          if (idx == LAST_IDX) begin
            state_next = S_FIN;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_RD;
          end
        end
      end

      default: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          ctl.status = ST_OK;
          state_next = S_IDLE;
          unique case (sts.op)
            CMD_RAISE: begin
              priority if (sts.code_zero) begin
                ctl.status = ST_RESERVED;
              end else if (hit) begin
                ctl.status = ST_OK;
              end else if (free_found) begin
                ctl.wr_new = 1'b1;
              end else begin
                ctl.status = ST_FULL;
              end
            end
            CMD_CLEAR: begin
              ctl.status = ST_OK;
            end
            CMD_QUERY: begin
              ctl.conf = conf;
            end
            default: begin
              ctl.emit_rec = have_pend;
            end
          endcase
        end
      end
    endcase
  end

endmodule

// ===== hdl/fcct_checker.sv =====
// ----------------------------------------------------------------------------
// fcct_checker: port-level checks of the fault code confirm table
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module fcct_checker import fcct_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_status,
  input logic        is_confirmed,
  input logic        record_valid,
  input logic [31:0] record_code,
  input logic [1:0]  record_flags,
  input logic [1:0]  record_count,
  input logic [2:0]  record_severity,
  input logic        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(record_code) && $stable(last))
    else $error("stalled result changed");

  // only read records may be followed by more results of the same command
  a_nonlast_is_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> record_valid)
    else $error("non-final result without a record");

  // a record carries ok status, no query answer, a nonzero code and the failed flag
  a_record_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_valid |-> result_status == ST_OK && !is_confirmed &&
                                  record_code != 32'd0 && record_flags[0])
    else $error("malformed read record");

  // results without a record carry zero code, count and severity, and are final
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !record_valid |-> record_code == 32'd0 && record_count == 2'd0 &&
                                   record_severity == 3'd0 && last)
    else $error("non-record result carries record data");

endmodule

bind fault_code_confirm_table fcct_checker u_fcct_checker (.*);

// ===== sim/fault_code_confirm_table_tb.sv =====
// ----------------------------------------------------------------------------
// fault_code_confirm_table_tb: self-checking bench of the fault code table
// Drives raise, clear, read and query commands through the valid/ready input
// channel, predicts every result from a shadow copy of the table and checks
// each output transfer field by field, under changing sender and receiver
// idle patterns.
// ----------------------------------------------------------------------------
module fault_code_confirm_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fcct_pkg::*;

  localparam int          TABLE_DEPTH  = 16;
  localparam int          WALK_CYCLES  = 2 * TABLE_DEPTH + 8;
  localparam int          DRAIN_LIMIT  = 20000;
  localparam int          REPORT_LIMIT = 10;
  localparam int          POOL_SIZE    = 24;
  localparam int          PHASE_ITEMS  = 43;
  localparam logic [31:0] MASK_ALL     = 32'hFFFF_FFFF;

  // one output transfer, in port order
  typedef struct packed {
    logic [1:0]  status;
    logic        confirmed;
    logic        rec_valid;
    logic [31:0] code;
    logic [1:0]  flags;
    logic [1:0]  count;
    logic [2:0]  sev;
    logic        last;
  } table_result_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd        = CMD_RAISE;
  logic [31:0] fault_code = '0;
  logic [2:0]  severity   = '0;
  logic [31:0] clear_mask = '0;
  logic [7:0]  read_limit = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  result_status;
  logic        is_confirmed;
  logic        record_valid;
  logic [31:0] record_code;
  logic [1:0]  record_flags;
  logic [1:0]  record_count;
  logic [2:0]  record_severity;
  logic        last;

  // shadow copy of the table, updated as each command transfers in
  logic [31:0] shadow_code  [TABLE_DEPTH];
  logic [1:0]  shadow_flags [TABLE_DEPTH];
  logic [1:0]  shadow_count [TABLE_DEPTH];
  logic [2:0]  shadow_sev   [TABLE_DEPTH];

  table_result_t pending_results [$];
  logic [31:0]   code_pool [POOL_SIZE];

  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int mismatches        = 0;
  int commands_sent     = 0;
  int results_seen      = 0;
  int records_seen      = 0;
  int full_raises       = 0;
  int reserved_raises   = 0;
  int confirmed_answers = 0;

  fault_code_confirm_table #(.ENTRIES(TABLE_DEPTH)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .fault_code      (fault_code),
    .severity        (severity),
    .clear_mask      (clear_mask),
    .read_limit      (read_limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_status   (result_status),
    .is_confirmed    (is_confirmed),
    .record_valid    (record_valid),
    .record_code     (record_code),
    .record_flags    (record_flags),
    .record_count    (record_count),
    .record_severity (record_severity),
    .last            (last)
  );

  always #5 clk = ~clk;

  // stall the result channel at the current phase's rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic string show_result(input table_result_t r);
    return $sformatf("status=%0d conf=%0b valid=%0b code=%h flags=%b count=%0d sev=%0d last=%0b",
                     r.status, r.confirmed, r.rec_valid, r.code, r.flags, r.count,
                     r.sev, r.last);
  endfunction

  // count every failure, print only the first few
  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("ERROR: %s", what);
    end
  endfunction

  // Apply one accepted command to the shadow table and queue the results it
  // must produce, oldest first.
  task automatic predict_command(input logic [1:0] op, input logic [31:0] code,
                                 input logic [2:0] sev, input logic [31:0] mask,
                                 input logic [7:0] limit);
    table_result_t r;
    int            hit;
    int            slot;
    int            cap;
    int            found [$];
    r      = '0;
    r.last = 1'b1;
    case (op)
      CMD_RAISE: begin
        hit  = -1;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (hit < 0 && shadow_code[i] == code) hit = i;
          if (slot < 0 && shadow_code[i] == '0) slot = i;
        end
        if (code == '0) begin
          // code zero marks a free entry, so it can never be raised
          r.status = ST_RESERVED;
          reserved_raises++;
        end else if (hit >= 0) begin
          // known code: mark failed, count up and saturate, confirm at the threshold
          shadow_flags[hit] = shadow_flags[hit] | FLAG_FAILED;
          if (shadow_count[hit] < CONFIRM_AT) shadow_count[hit] = shadow_count[hit] + 2'd1;
          if (shadow_count[hit] == CONFIRM_AT) begin
            shadow_flags[hit] = shadow_flags[hit] | FLAG_CONFIRMED;
          end
          shadow_sev[hit] = sev;
        end else if (slot < 0) begin
          r.status = ST_FULL;
          full_raises++;
        end else begin
          shadow_code[slot]  = code;
          shadow_flags[slot] = FLAG_FAILED;
          shadow_count[slot] = 2'd1;
          shadow_sev[slot]   = sev;
        end
        pending_results.push_back(r);
      end
      CMD_CLEAR: begin
        // a shared bit frees the entry; the all-ones mask frees everything
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (mask == MASK_ALL || (shadow_code[i] & mask) != '0) begin
            shadow_code[i]  = '0;
            shadow_flags[i] = '0;
            shadow_count[i] = '0;
            shadow_sev[i]   = '0;
          end
        end
        pending_results.push_back(r);
      end
      CMD_READ: begin
        cap = (int'(limit) > int'(MAX_READ)) ? int'(MAX_READ) : int'(limit);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (shadow_code[i] != '0 && found.size() < cap) found.push_back(i);
        end
        if (found.size() == 0) begin
          // nothing to return: one empty result closes the read
          pending_results.push_back(r);
        end else begin
          foreach (found[k]) begin
            r.rec_valid = 1'b1;
            r.code      = shadow_code[found[k]];
            r.flags     = shadow_flags[found[k]];
            r.count     = shadow_count[found[k]];
            r.sev       = shadow_sev[found[k]];
            r.last      = (k == found.size() - 1);
            pending_results.push_back(r);
          end
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (code != '0 && shadow_code[i] == code && (shadow_flags[i] & FLAG_CONFIRMED) != '0) begin
            r.confirmed = 1'b1;
          end
        end
        if (r.confirmed) confirmed_answers++;
        pending_results.push_back(r);
      end
    endcase
  endtask

  // Present one command after a random idle gap, hold it until it transfers,
  // then predict its results. Starts and ends just after a falling edge.
  task automatic send_command(input logic [1:0] op, input logic [31:0] code,
                              input logic [2:0] sev, input logic [31:0] mask,
                              input logic [7:0] limit);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = op;
    fault_code = code;
    severity   = sev;
    clear_mask = mask;
    read_limit = limit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(op, code, sev, mask, limit);
    commands_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has transferred out, or until the wait limit runs out.
  task automatic wait_results_done(input int max_cycles);
    int waited;
    waited   = 0;
    in_valid = 1'b0;
    while (pending_results.size() != 0 && waited < max_cycles) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Check every output transfer against the oldest pending prediction.
  always @(posedge clk) begin : result_check
    table_result_t seen;
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {result_status, is_confirmed, record_valid, record_code, record_flags,
              record_count, record_severity, last};
      results_seen++;
      if (record_valid) records_seen++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result %s", show_result(seen)));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          note_failure($sformatf("result %0d: expected %s, got %s", results_seen,
                                 show_result(want), show_result(seen)));
        end
      end
    end
  end

  // One code raised four times: count 1, 2, 3 (confirmed), then saturates
  // while the severity keeps being overwritten. Then the code-zero cases.
  task automatic test_confirm_counting();
    send_command(CMD_RAISE, 32'hFFFF_FFFF, 3'd7, '0, '0);
    send_command(CMD_RAISE, 32'hFFFF_FFFF, 3'd1, '0, '0);
    send_command(CMD_RAISE, 32'hFFFF_FFFF, 3'd2, '0, '0);
    send_command(CMD_RAISE, 32'hFFFF_FFFF, 3'd5, '0, '0);
    send_command(CMD_QUERY, 32'hFFFF_FFFF, 3'd0, '0, '0);
    send_command(CMD_RAISE, 32'h0, 3'd7, MASK_ALL, 8'hFF);
    send_command(CMD_QUERY, 32'h0, 3'd7, MASK_ALL, 8'hFF);
  endtask

  // Fill the remaining fifteen entries, then raise one more new code.
  task automatic test_table_full();
    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
      send_command(CMD_RAISE, 32'h1 << k, 3'(k), '0, '0);
    end
    send_command(CMD_RAISE, 32'h8000_0000, 3'd4, '0, '0);
  endtask

  // Full table: the largest limit stops at the read cap, limit zero returns
  // only the empty closing result.
  task automatic test_read_limits();
    send_command(CMD_READ, 32'h0, 3'd0, '0, 8'hFF);
    send_command(CMD_READ, MASK_ALL, 3'd7, MASK_ALL, 8'h00);
  endtask

  task automatic test_clear_all();
    send_command(CMD_CLEAR, 32'h0, 3'd0, MASK_ALL, 8'h00);
    send_command(CMD_READ, 32'h0, 3'd0, '0, 8'd16);
  endtask

  // Mostly raises from a small pool of sparse codes, so entries get hit
  // again, confirm, fill the table, and get freed by narrow masks.
  task automatic send_random_command();
    logic [1:0]  op;
    logic [31:0] code;
    logic [31:0] mask;
    logic [7:0]  limit;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) op = CMD_RAISE;
    else if (pick < 63) op = CMD_CLEAR;
    else if (pick < 80) op = CMD_READ;
    else op = CMD_QUERY;
    pick = $urandom_range(0, 99);
    if (pick < 80) code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (pick < 93) code = $urandom;
    else code = '0;
    pick = $urandom_range(0, 99);
    if (pick < 50) mask = 32'h1 << $urandom_range(0, 31);
    else if (pick < 65) mask = code_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (pick < 75) mask = '0;
    else if (pick < 85) mask = MASK_ALL;
    else mask = $urandom;
    if ($urandom_range(0, 99) < 60) limit = 8'($urandom_range(0, 17));
    else limit = 8'($urandom_range(0, 255));
    send_command(op, code, 3'($urandom_range(0, 7)), mask, limit);
  endtask

  // Four idle patterns; halfway through each, hold the sender until the
  // result channel has fully drained.
  task automatic test_random_traffic();
    for (int i = 0; i < POOL_SIZE; i++) begin
      code_pool[i] = ($urandom & $urandom & $urandom) | (32'h1 << $urandom_range(0, 31));
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) wait_results_done(DRAIN_LIMIT);
        send_random_command();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_code[i]  = '0;
      shadow_flags[i] = '0;
      shadow_count[i] = '0;
      shadow_sev[i]   = '0;
    end
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    test_confirm_counting();
    test_table_full();
    test_read_limits();
    test_clear_all();
    test_random_traffic();

    // drain, then watch a full table walk for stray transfers
    wait_results_done(DRAIN_LIMIT);
    repeat (WALK_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    end

    $display("Covered %0d commands and %0d result transfers, %0d of them stored records.",
             commands_sent, results_seen, records_seen);
    $display("Rejected raises: %0d on a full table, %0d of code zero; %0d confirmed answers.",
             full_raises, reserved_raises, confirmed_answers);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard: far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
